### sv/segmented_prime_sieve_top_macros.svh
// Assertion macros used by the port-level checker of the prime sieve.
`ifndef SEGMENTED_PRIME_SIEVE_TOP_MACROS_SVH
`define SEGMENTED_PRIME_SIEVE_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, held off during reset.
`define SPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, held off during reset.
`define SPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/sps_pkg.sv
// Shared types and constants of the segmented prime sieve.
`timescale 1ns / 1ps

package sps_pkg;

  localparam int VALUE_W   = 16;
  localparam int COUNT_W   = 13;
  localparam int SQ_W      = 8;
  localparam int RT_W      = 9;
  localparam int SMALL_CAP = 255;
  localparam int DIVB_W    = $clog2(VALUE_W);
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_PRIME_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_LIMIT = 1'b1;

  localparam logic [COUNT_W-1:0] PRIME_COUNT_RESET = 13'd1024;
  localparam logic [VALUE_W-1:0] VALUE_LIMIT_RESET = 16'd12140;

  typedef enum logic {
    REQ_NEXT,
    REQ_RESTART
  } req_kind_t;

  typedef struct packed {
    logic      valid;
    req_kind_t kind;
  } req_t;

endpackage

### sv/sps_front.sv
// Request front end: accepts and classifies requests into a two-entry queue.
`timescale 1ns / 1ps

module sps_front import sps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic restart,
  output req_t req,
  input  logic req_pop
);

  logic [1:0] used;
  logic       wr_ptr;
  logic       rd_ptr;
  req_kind_t  slot [2];
  logic       push;
  logic       pop;

  assign in_ready  = (used != 2'd2);
  assign push      = in_valid && in_ready;
  assign req.valid = (used != 2'd0);
  assign req.kind  = slot[rd_ptr];
  assign pop       = req_pop && req.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      used   <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= restart ? REQ_RESTART : REQ_NEXT;
        wr_ptr       <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      used <= used + 2'(push) - 2'(pop);
    end
  end

endmodule

### sv/sps_engine.sv
// Sieve engine: base prime build, segment refill, bitmap scan and result register.
`timescale 1ns / 1ps

module sps_engine import sps_pkg::*; #(
  parameter int SEGMENT_SIZE    = 4096,
  parameter int MAX_BASE_PRIMES = 54
) (
  input  logic                 clk,
  input  logic                 rst,
  input  req_t                 req,
  output logic                 req_pop,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VALUE_W-1:0]   cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VALUE_W-1:0]   prime_value,
  output logic [COUNT_W-1:0]   prime_index,
  output logic                 is_last,
  output logic                 exhausted
);

  localparam int SEG_W  = $clog2(SEGMENT_SIZE);
  localparam int TBL_AW = $clog2(MAX_BASE_PRIMES);
  localparam int TOT_W  = $clog2(MAX_BASE_PRIMES + 1);
  localparam int CUR_W  = (SEG_W + 1 > TOT_W) ? SEG_W + 1 : TOT_W;
  localparam int EXT_W  = VALUE_W + 1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_SQRT, ST_CLR, ST_SV_RD, ST_SV_CK, ST_STRIKE,
    ST_CO_RD, ST_CO_CK, ST_SMALL, ST_SCAN, ST_SCAN_CK, ST_FCLR, ST_FK,
    ST_FQ, ST_DIV, ST_FM, ST_FSTR, ST_OUT
  } state_t;

  state_t               state;
  logic [COUNT_W-1:0]   prime_count;
  logic [VALUE_W-1:0]   value_limit;
  logic [RT_W-1:0]      root;
  logic [SQ_W-1:0]      sq;
  logic [RT_W-1:0]      sv_p;
  logic [RT_W-1:0]      sv_j;
  logic [TOT_W-1:0]     base_total;
  logic [VALUE_W-1:0]   seg_low;
  logic [CUR_W-1:0]     cursor;
  logic [COUNT_W-1:0]   emitted;
  logic                 seg_phase;
  logic [SEG_W-1:0]     fill_cnt;
  logic [TOT_W-1:0]     fk;
  logic [SQ_W-1:0]      q;
  logic [SQ_W-1:0]      rem;
  logic [DIVB_W-1:0]    div_bit;
  logic [EXT_W-1:0]     mult;
  logic [SEG_W-1:0]     scan_pos;
  logic [VALUE_W-1:0]   res_value;
  logic                 res_found;
  logic                 ret_scan;

  // Memories
  logic                 mark_mem [SMALL_CAP + 1];
  logic [SQ_W-1:0]      tbl_mem  [MAX_BASE_PRIMES];
  logic                 bm_mem   [SEGMENT_SIZE];

  logic                 mk_we, mk_wdata, mk_rdata;
  logic [SQ_W-1:0]      mk_waddr, mk_raddr;
  logic                 tb_we;
  logic [TBL_AW-1:0]    tb_waddr, tb_raddr;
  logic [SQ_W-1:0]      tb_wdata, tb_rdata;
  logic                 bm_we, bm_wdata, bm_rdata;
  logic [SEG_W-1:0]     bm_waddr, bm_raddr;

  // Derived values
  logic [RT_W-1:0]      root_inc;
  logic [2*RT_W-1:0]    root_sq;
  logic [2*RT_W-1:0]    p_sq;
  logic [EXT_W-1:0]     hi_full;
  logic [VALUE_W-1:0]   seg_hi;
  logic [EXT_W-1:0]     seg_len;
  logic [EXT_W-1:0]     strike_off;
  logic [SQ_W:0]        rem_shift;
  logic [SQ_W-1:0]      rem_next;
  logic [SQ_W-1:0]      adjust;
  logic [EXT_W-1:0]     m_base;
  logic [VALUE_W-1:0]   q_sq;
  logic                 take_req;

  assign cfg_ready = 1'b1;
  assign take_req  = (state == ST_IDLE) && req.valid && !out_valid;
  assign req_pop   = take_req;

  assign root_inc   = root + RT_W'(1);
  assign root_sq    = root_inc * root_inc;
  assign p_sq       = sv_p * sv_p;
  assign hi_full    = {1'b0, seg_low} + EXT_W'(SEGMENT_SIZE - 1);
  assign seg_hi     = (hi_full > {1'b0, value_limit}) ? value_limit : hi_full[VALUE_W-1:0];
  assign seg_len    = {1'b0, seg_hi} - {1'b0, seg_low} + EXT_W'(1);
  assign strike_off = mult - {1'b0, seg_low};
  assign rem_shift  = {rem, seg_low[div_bit]};
  assign rem_next   = (rem_shift >= {1'b0, q}) ? SQ_W'(rem_shift - {1'b0, q})
                                               : rem_shift[SQ_W-1:0];
  assign adjust     = (rem == '0) ? '0 : q - rem;
  assign m_base     = {1'b0, seg_low} + EXT_W'(adjust);
  assign q_sq       = VALUE_W'(q * q);

  always_comb begin
    mk_we    = 1'b0;
    mk_wdata = 1'b0;
    mk_waddr = sv_j[SQ_W-1:0];
    mk_raddr = sv_p[SQ_W-1:0];
    tb_we    = 1'b0;
    tb_waddr = base_total[TBL_AW-1:0];
    tb_wdata = sv_p[SQ_W-1:0];
    tb_raddr = (state == ST_FK) ? fk[TBL_AW-1:0] : cursor[TBL_AW-1:0];
    bm_we    = 1'b0;
    bm_wdata = 1'b1;
    bm_waddr = fill_cnt;
    bm_raddr = cursor[SEG_W-1:0];
    unique case (state)
      ST_CLR: begin
        mk_we = 1'b1;
      end
      ST_STRIKE: begin
        if (sv_j <= {1'b0, sq}) begin
          mk_we    = 1'b1;
          mk_wdata = 1'b1;
        end
      end
      ST_CO_CK: begin
        if (!mk_rdata && base_total < TOT_W'(MAX_BASE_PRIMES)) begin
          tb_we = 1'b1;
        end
      end
      ST_FCLR: begin
        bm_we = 1'b1;
      end
      ST_FSTR: begin
        if (mult <= {1'b0, seg_hi}) begin
          bm_we    = 1'b1;
          bm_wdata = 1'b0;
          bm_waddr = strike_off[SEG_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mk_we) begin
      mark_mem[mk_waddr] <= mk_wdata;
    end
    mk_rdata <= mark_mem[mk_raddr];
  end

  always_ff @(posedge clk) begin
    if (tb_we) begin
      tbl_mem[tb_waddr] <= tb_wdata;
    end
    tb_rdata <= tbl_mem[tb_raddr];
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm_mem[bm_waddr] <= bm_wdata;
    end
    bm_rdata <= bm_mem[bm_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_count <= PRIME_COUNT_RESET;
      value_limit <= VALUE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PRIME_COUNT: prime_count <= cfg_data[COUNT_W-1:0];
        CFG_VALUE_LIMIT: value_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      base_total <= '0;
      seg_phase  <= 1'b0;
      seg_low    <= '0;
      cursor     <= '0;
      emitted    <= '0;
      ret_scan   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (take_req) begin
            if (req.kind == REQ_RESTART) begin
              seg_phase  <= 1'b0;
              base_total <= '0;
            end
            state <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          if (!seg_phase && base_total == '0) begin
            root  <= '0;
            state <= ST_SQRT;
          end else if (emitted >= prime_count) begin
            res_found <= 1'b0;
            state     <= ST_OUT;
          end else if (!seg_phase) begin
            state <= ST_SMALL;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_SQRT: begin
          if (root_sq <= {2'b00, value_limit}) begin
            root <= root_inc;
          end else begin
            sq    <= (root >= RT_W'(SMALL_CAP - 2)) ? SQ_W'(SMALL_CAP)
                                                    : SQ_W'(root + RT_W'(2));
            sv_j  <= '0;
            state <= ST_CLR;
          end
        end
        ST_CLR: begin
          sv_j <= sv_j + RT_W'(1);
          if (sv_j == {1'b0, sq}) begin
            sv_p  <= RT_W'(2);
            state <= ST_SV_RD;
          end
        end
        ST_SV_RD: begin
          state <= ST_SV_CK;
        end
        ST_SV_CK: begin
          if (p_sq > {{RT_W{1'b0}}, 1'b0, sq}) begin
            sv_p       <= RT_W'(2);
            base_total <= '0;
            seg_low    <= VALUE_W'({1'b0, sq}) + VALUE_W'(1);
            state      <= ST_CO_RD;
          end else if (!mk_rdata) begin
            sv_j  <= p_sq[RT_W-1:0];
            state <= ST_STRIKE;
          end else begin
            sv_p  <= sv_p + RT_W'(1);
            state <= ST_SV_RD;
          end
        end
        ST_STRIKE: begin
          if (sv_j <= {1'b0, sq}) begin
            sv_j <= sv_j + sv_p;
          end else begin
            sv_p  <= sv_p + RT_W'(1);
            state <= ST_SV_RD;
          end
        end
        ST_CO_RD: begin
          if (sv_p > {1'b0, sq}) begin
            cursor    <= '0;
            emitted   <= '0;
            seg_phase <= 1'b0;
            state     <= ST_DISPATCH;
          end else begin
            state <= ST_CO_CK;
          end
        end
        ST_CO_CK: begin
          state <= ST_CO_RD;
          if (!mk_rdata && base_total >= TOT_W'(MAX_BASE_PRIMES)) begin
            // Table full: this prime opens the first segment and collection stops.
            seg_low <= VALUE_W'(sv_p);
            sv_p    <= RT_W'(SMALL_CAP + 1);
          end else begin
            if (!mk_rdata) begin
              base_total <= base_total + TOT_W'(1);
            end
            sv_p <= sv_p + RT_W'(1);
          end
        end
        ST_SMALL: begin
          res_value <= VALUE_W'(tb_rdata);
          res_found <= 1'b1;
          if (cursor + CUR_W'(1) >= CUR_W'(base_total)) begin
            seg_phase <= 1'b1;
            cursor    <= '0;
            if (seg_low <= value_limit) begin
              ret_scan <= 1'b0;
              fill_cnt <= '0;
              state    <= ST_FCLR;
            end else begin
              state <= ST_OUT;
            end
          end else begin
            cursor <= cursor + CUR_W'(1);
            state  <= ST_OUT;
          end
        end
        ST_SCAN: begin
          if (seg_low > value_limit) begin
            res_found <= 1'b0;
            state     <= ST_OUT;
          end else if (EXT_W'(cursor) < seg_len) begin
            scan_pos <= cursor[SEG_W-1:0];
            cursor   <= cursor + CUR_W'(1);
            state    <= ST_SCAN_CK;
          end else if (seg_hi >= value_limit) begin
            res_found <= 1'b0;
            state     <= ST_OUT;
          end else begin
            seg_low  <= seg_hi + VALUE_W'(1);
            cursor   <= '0;
            ret_scan <= 1'b1;
            fill_cnt <= '0;
            state    <= ST_FCLR;
          end
        end
        ST_SCAN_CK: begin
          if (bm_rdata) begin
            res_value <= seg_low + VALUE_W'(scan_pos);
            res_found <= 1'b1;
            state     <= ST_OUT;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_FCLR: begin
          fill_cnt <= fill_cnt + SEG_W'(1);
          if (fill_cnt == SEG_W'(SEGMENT_SIZE - 1)) begin
            fk    <= '0;
            state <= ST_FK;
          end
        end
        ST_FK: begin
          if (fk >= base_total) begin
            state <= ret_scan ? ST_SCAN : ST_OUT;
          end else begin
            state <= ST_FQ;
          end
        end
        ST_FQ: begin
          q <= tb_rdata;
          if (tb_rdata < SQ_W'(2)) begin
            fk    <= fk + TOT_W'(1);
            state <= ST_FK;
          end else begin
            rem     <= '0;
            div_bit <= DIVB_W'(VALUE_W - 1);
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= rem_next;
          if (div_bit == '0) begin
            state <= ST_FM;
          end else begin
            div_bit <= div_bit - DIVB_W'(1);
          end
        end
        ST_FM: begin
          mult  <= (m_base < {1'b0, q_sq}) ? {1'b0, q_sq} : m_base;
          state <= ST_FSTR;
        end
        ST_FSTR: begin
          if (mult <= {1'b0, seg_hi}) begin
            mult <= mult + EXT_W'(q);
          end else begin
            fk    <= fk + TOT_W'(1);
            state <= ST_FK;
          end
        end
        ST_OUT: begin
          out_valid   <= 1'b1;
          prime_value <= res_found ? res_value : '0;
          prime_index <= res_found ? emitted : '0;
          is_last     <= res_found && (emitted + COUNT_W'(1) == prime_count);
          exhausted   <= !res_found;
          if (res_found) begin
            emitted <= emitted + COUNT_W'(1);
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/segmented_prime_sieve_top.sv
// Top level of the segmented prime sieve: request queue and sieve engine.
`timescale 1ns / 1ps

//  Channel   Signals                                   Direction  Transaction
//  in        in_valid, in_ready, restart               input      one prime request
//  out       out_valid, out_ready, prime_value,        output     one result
//            prime_index, is_last, exhausted
//  cfg       cfg_valid, cfg_ready, cfg_index, cfg_data input      one register write
//
//  A request from the base table passes through the dispatch, small-table and output states
//  before its result shows; in the segment phase each bitmap position scanned takes a read
//  state and a check state, set by the single read port of the segment bitmap. The engine
//  takes the next request in the cycle after the result leaves. Each new segment sets
//  every bitmap bit, then for each base prime finds its first multiple by division and
//  strikes its multiples. The first request after reset or a restart builds the base primes:
//  a root search, a clear of the marks, a short sieve of the candidates up to sq, then a
//  pass over the small candidates. Reset is synchronous; the two-entry request queue keeps
//  accepting until it is full while a result waits on a stalled output.

module segmented_prime_sieve_top import sps_pkg::*; #(
  parameter int SEGMENT_SIZE    = 4096,
  parameter int MAX_BASE_PRIMES = 54
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 restart,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VALUE_W-1:0]   prime_value,
  output logic [COUNT_W-1:0]   prime_index,
  output logic                 is_last,
  output logic                 exhausted,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VALUE_W-1:0]   cfg_data
);

  // The front end tags each transaction as a restart or a plain next-prime request.
  req_t req;
  logic req_pop;

  sps_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .restart  (restart),
    .req      (req),
    .req_pop  (req_pop)
  );

  // The engine holds the configuration registers, the three stores and the output
  // register, and takes the next request only once its output register is empty.
  sps_engine #(
    .SEGMENT_SIZE    (SEGMENT_SIZE),
    .MAX_BASE_PRIMES (MAX_BASE_PRIMES)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .req_pop     (req_pop),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .prime_value (prime_value),
    .prime_index (prime_index),
    .is_last     (is_last),
    .exhausted   (exhausted)
  );

endmodule

### sv/sps_checker.sv
// Port-level checker for the prime sieve and its bind to the top level.
`timescale 1ns / 1ps
`include "segmented_prime_sieve_top_macros.svh"

module sps_checker import sps_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [VALUE_W-1:0] prime_value,
  input logic [COUNT_W-1:0] prime_index,
  input logic               is_last,
  input logic               exhausted
);

  `SPS_ASSERT_NOW(a_exhausted_empty, out_valid && exhausted, prime_value == '0 && prime_index == '0 && !is_last, "exhausted result carries data")

  `SPS_ASSERT_NOW(a_prime_at_least_two, out_valid && !exhausted, prime_value >= VALUE_W'(2), "produced prime below two")

  `SPS_ASSERT_NOW(a_first_is_two, out_valid && !exhausted && prime_index == '0, prime_value == VALUE_W'(2), "first prime is not two")

  `SPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(prime_value), "stalled result changed")

endmodule

bind segmented_prime_sieve_top sps_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .prime_value (prime_value),
  .prime_index (prime_index),
  .is_last     (is_last),
  .exhausted   (exhausted)
);

### bench/tb_segmented_prime_sieve_top.sv
// Self-checking testbench for the segmented prime sieve top level.
`timescale 1ns / 1ps

// The bench drives prime requests into the sieve and predicts every result
// with its own segmented sieve written in plain SystemVerilog. A short table of
// directed transactions comes first, then random phases. Each phase writes
// both registers while the block is idle and opens with a restart. Only after
// that restart are any requests sent.
module tb_segmented_prime_sieve_top;
  import sps_pkg::*;

  localparam int SEG_SIZE    = 4096;
  localparam int BASE_MAX    = 54;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int SETTLE      = 40;
  localparam int RAND_PHASES = 9;
  localparam int PHASE_ITEMS = 55;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] index;
    logic               last;
    logic               exh;
  } prime_result_t;

  // One directed row is either a register write or a run of requests. A run
  // carries a typed result only where it can be checked by eye.
  typedef struct {
    bit                  is_write;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [VALUE_W-1:0]  reg_data;
    req_kind_t           kind;
    int                  repeats;
    bit                  typed;
    prime_result_t       res;
  } directed_row_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic                 restart;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [VALUE_W-1:0]   prime_value;
  logic [COUNT_W-1:0]   prime_index;
  logic                 is_last;
  logic                 exhausted;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VALUE_W-1:0]   cfg_data;

  segmented_prime_sieve_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .restart(restart),
    .out_valid(out_valid), .out_ready(out_ready),
    .prime_value(prime_value), .prime_index(prime_index),
    .is_last(is_last), .exhausted(exhausted),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // The bench's own copy of the sieve state and of the two registers.
  logic [7:0]   sv_base [BASE_MAX];
  int unsigned  sv_base_total;
  bit           sv_bitmap [SEG_SIZE];
  longint unsigned sv_seg_low;
  int unsigned  sv_cursor;
  int unsigned  sv_emitted;
  bit           sv_in_segments;
  int unsigned  sv_count;
  int unsigned  sv_limit;

  prime_result_t pending_primes[$];
  int  fail_count     = 0;
  int  cycle_count    = 0;
  int  burst_left;
  int  sent_total;
  int  got_total      = 0;
  int  exhausted_seen = 0;
  int  last_seen      = 0;
  int  writes_done;
  int  stall_mode     = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Resets the model's state the way the block comes out of reset.
  function automatic void sieve_reset();
    foreach (sv_base[i]) sv_base[i] = '0;
    foreach (sv_bitmap[i]) sv_bitmap[i] = 1'b0;
    sv_base_total  = 0;
    sv_seg_low     = 0;
    sv_cursor      = 0;
    sv_emitted     = 0;
    sv_in_segments = 1'b0;
    sv_count       = 32'(PRIME_COUNT_RESET);
    sv_limit       = 32'(VALUE_LIMIT_RESET);
  endfunction

  // Sieves 2..S with S = isqrt(limit) + 2, capped at 255, into the base table.
  function automatic void build_base_primes();
    bit          struck [256];
    int unsigned root;
    int unsigned top;
    int unsigned p;
    int unsigned j;
    root = 0;
    while ((root + 1) * (root + 1) <= sv_limit) root++;
    top = (root + 2 > SMALL_CAP) ? SMALL_CAP : root + 2;
    foreach (struck[i]) struck[i] = 1'b0;
    struck[0] = 1'b1;
    struck[1] = 1'b1;
    for (p = 2; p * p <= top; p++)
      if (!struck[p])
        for (j = p * p; j <= top; j += p) struck[j] = 1'b1;
    sv_base_total = 0;
    sv_seg_low    = 64'(top + 1);
    for (p = 2; p <= top; p++) begin
      if (struck[p]) continue;
      if (sv_base_total < BASE_MAX) begin
        sv_base[sv_base_total] = p[7:0];
        sv_base_total++;
      end else begin
        sv_seg_low = 64'(p);
        break;
      end
    end
    sv_cursor      = 0;
    sv_emitted     = 0;
    sv_in_segments = 1'b0;
  endfunction

  function automatic longint unsigned segment_top();
    longint unsigned hi;
    hi = sv_seg_low + SEG_SIZE - 1;
    return (hi > sv_limit) ? longint'(sv_limit) : hi;
  endfunction

  function automatic void strike_segment();
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned m;
    longint unsigned q;
    lo = sv_seg_low;
    hi = segment_top();
    foreach (sv_bitmap[i]) sv_bitmap[i] = 1'b1;
    for (int k = 0; k < sv_base_total && k < BASE_MAX; k++) begin
      q = 64'(sv_base[k]);
      if (q < 2) continue;
      m = (lo + q - 1) / q * q;
      if (m < q * q) m = q * q;
      for (; m <= hi; m += q) sv_bitmap[(m - lo) & (SEG_SIZE - 1)] = 1'b0;
    end
  endfunction

  // Scans on for the next unstruck value, refilling segments as it goes.
  function automatic bit next_segment_prime(output longint unsigned val);
    longint unsigned hi;
    longint unsigned len;
    val = 0;
    forever begin
      if (sv_seg_low > sv_limit) return 1'b0;
      hi  = segment_top();
      len = hi - sv_seg_low + 1;
      if (len > SEG_SIZE) len = 64'(SEG_SIZE);
      while (sv_cursor < len) begin
        sv_cursor++;
        if (sv_bitmap[sv_cursor - 1]) begin
          val = sv_seg_low + sv_cursor - 1;
          return 1'b1;
        end
      end
      if (hi >= sv_limit) return 1'b0;
      sv_seg_low = hi + 1;
      sv_cursor  = 0;
      strike_segment();
    end
  endfunction

  // Works out the result of one accepted request and advances the state.
  function automatic prime_result_t predict_prime(req_kind_t kind);
    prime_result_t   r;
    longint unsigned val;
    bit              found;
    int unsigned     c;
    val   = 0;
    found = 1'b0;
    if (kind == REQ_RESTART) begin
      sv_in_segments = 1'b0;
      sv_base_total  = 0;
    end
    if (!sv_in_segments && sv_base_total == 0) build_base_primes();
    if (sv_emitted < sv_count) begin
      if (!sv_in_segments) begin
        c     = (sv_cursor < BASE_MAX) ? sv_cursor : 0;
        val   = 64'(sv_base[c]);
        found = 1'b1;
        sv_cursor++;
        if (sv_cursor >= sv_base_total) begin
          sv_in_segments = 1'b1;
          sv_cursor      = 0;
          if (sv_seg_low <= sv_limit) strike_segment();
        end
      end else begin
        found = next_segment_prime(val);
      end
    end
    if (found) begin
      r.value = val[VALUE_W-1:0];
      r.index = sv_emitted[COUNT_W-1:0];
      sv_emitted++;
      r.last  = (sv_emitted == sv_count);
      r.exh   = 1'b0;
    end else begin
      r.value = '0;
      r.index = '0;
      r.last  = 1'b0;
      r.exh   = 1'b1;
    end
    return r;
  endfunction

  // Sends one request, with a random gap in front of it at the end of a burst.
  task automatic send_request(req_kind_t kind, bit typed, prime_result_t typed_res);
    int            gap;
    prime_result_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    restart  <= (kind == REQ_RESTART);
    do @(posedge clk); while (!in_ready);
    r = predict_prime(kind);
    pending_primes = {pending_primes, (typed ? typed_res : r)};
    sent_total++;
    burst_left--;
  endtask

  // Lowers valid and waits until every outstanding prime has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_primes.size() != 0) @(posedge clk);
  endtask

  // Writes one register once the block is idle and has settled.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
    drain_results();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_PRIME_COUNT) sv_count = 32'(data[COUNT_W-1:0]);
    else sv_limit = 32'(data);
    writes_done++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic prime_result_t mk_res(int v, int i, int l, int e);
    prime_result_t r;
    r.value = v[VALUE_W-1:0];
    r.index = i[COUNT_W-1:0];
    r.last  = l[0];
    r.exh   = e[0];
    return r;
  endfunction

  function automatic directed_row_t req_row(req_kind_t k, int n, bit t, prime_result_t r);
    directed_row_t d;
    d.is_write = 1'b0;
    d.reg_idx  = CFG_PRIME_COUNT;
    d.reg_data = '0;
    d.kind     = k;
    d.repeats  = n;
    d.typed    = t;
    d.res      = r;
    return d;
  endfunction

  function automatic directed_row_t wr_row(logic [CFG_IDX_W-1:0] idx, int data);
    directed_row_t d;
    d          = req_row(REQ_NEXT, 0, 1'b0, mk_res(0, 0, 0, 0));
    d.is_write = 1'b1;
    d.reg_idx  = idx;
    d.reg_data = data[VALUE_W-1:0];
    return d;
  endfunction

  // Receiver: out_ready follows a randomly redrawn stall mode, from always ready
  // through to mostly stalled.
  always @(negedge clk) begin
    if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= ((cycle_count / 7) % 3 != 0);
    endcase
  end

  // Compares every result transaction with the oldest pending expectation.
  always @(posedge clk) begin
    prime_result_t e;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && out_ready) begin
      if (pending_primes.size() == 0) begin
        $error("result with no request outstanding: value %0d", prime_value);
        fail_count++;
      end else begin
        e = pending_primes.pop_front();
        got_total <= got_total + 1;
        if (e.exh) exhausted_seen <= exhausted_seen + 1;
        if (e.last) last_seen <= last_seen + 1;
        if (prime_value !== e.value) begin
          $error("prime_value: expected %0d, got %0d", e.value, prime_value);
          fail_count++;
        end
        if (prime_index !== e.index) begin
          $error("prime_index: expected %0d, got %0d", e.index, prime_index);
          fail_count++;
        end
        if (is_last !== e.last) begin
          $error("is_last: expected %0b, got %0b", e.last, is_last);
          fail_count++;
        end
        if (exhausted !== e.exh) begin
          $error("exhausted: expected %0b, got %0b", e.exh, exhausted);
          fail_count++;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("segmented_prime_sieve_top test failed");
      $finish;
    end
  end

  initial begin
    directed_row_t rows[$];
    int            pick;
    int            n_items;
    logic [VALUE_W-1:0] lim_val;
    logic [VALUE_W-1:0] cnt_val;
    in_valid       = 1'b0;
    restart        = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_PRIME_COUNT;
    cfg_data       = '0;
    burst_left     = 0;
    sent_total     = 0;
    writes_done    = 0;
    sieve_reset();
    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Under the reset registers the sequence opens 2, 3, 5.
    // A count of one flags prime 2 as the last, and the next request finds
    // the count already reached. A limit of 50 holds fifteen primes, so the
    // sixteenth request finds the limit passed. The widest settings close it.
    rows = {rows, req_row(REQ_RESTART, 1, 1'b1, mk_res(2, 0, 0, 0))};
    rows = {rows, req_row(REQ_NEXT, 1, 1'b1, mk_res(3, 1, 0, 0))};
    rows = {rows, req_row(REQ_NEXT, 1, 1'b1, mk_res(5, 2, 0, 0))};
    rows = {rows, req_row(REQ_NEXT, 4, 1'b0, mk_res(0, 0, 0, 0))};
    rows = {rows, wr_row(CFG_PRIME_COUNT, 1)};
    rows = {rows, req_row(REQ_RESTART, 1, 1'b1, mk_res(2, 0, 1, 0))};
    rows = {rows, req_row(REQ_NEXT, 1, 1'b1, mk_res(0, 0, 0, 1))};
    rows = {rows, wr_row(CFG_PRIME_COUNT, 6542)};
    rows = {rows, wr_row(CFG_VALUE_LIMIT, 50)};
    rows = {rows, req_row(REQ_RESTART, 1, 1'b1, mk_res(2, 0, 0, 0))};
    rows = {rows, req_row(REQ_NEXT, 13, 1'b0, mk_res(0, 0, 0, 0))};
    rows = {rows, req_row(REQ_NEXT, 1, 1'b1, mk_res(47, 14, 0, 0))};
    rows = {rows, req_row(REQ_NEXT, 1, 1'b1, mk_res(0, 0, 0, 1))};
    rows = {rows, wr_row(CFG_VALUE_LIMIT, 65535)};
    rows = {rows, req_row(REQ_RESTART, 1, 1'b1, mk_res(2, 0, 0, 0))};
    rows = {rows, req_row(REQ_NEXT, 2, 1'b0, mk_res(0, 0, 0, 0))};
    rows = {rows, req_row(REQ_RESTART, 1, 1'b1, mk_res(2, 0, 0, 0))};

    foreach (rows[i]) begin
      if (rows[i].is_write) begin
        write_register(rows[i].reg_idx, rows[i].reg_data);
      end else begin
        for (int k = 0; k < rows[i].repeats; k++)
          send_request(rows[i].kind, rows[i].typed, rows[i].res);
      end
    end

    // Random phases. The first three pin the registers at their extremes.
    // Small limits are favoured so that most phases run through to exhaustion,
    // and small counts so that the last prime is flagged often.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin cnt_val = 16'd6542; lim_val = 16'd65535; end
        1: begin cnt_val = 16'd1;    lim_val = 16'd50;    end
        2: begin cnt_val = 16'd6542; lim_val = 16'd50;    end
        default: begin
          pick    = $urandom_range(0, 3);
          cnt_val = (pick == 0) ? VALUE_W'($urandom_range(1, 6542))
                                : VALUE_W'($urandom_range(1, 60));
          lim_val = (pick == 1) ? VALUE_W'($urandom_range(50, 65535))
                                : VALUE_W'($urandom_range(50, 400));
        end
      endcase
      write_register(CFG_PRIME_COUNT, cnt_val);
      write_register(CFG_VALUE_LIMIT, lim_val);
      n_items = PHASE_ITEMS;
      send_request(REQ_RESTART, 1'b0, mk_res(0, 0, 0, 0));
      for (int k = 1; k < n_items; k++) begin
        // Once in each phase the sender holds off until all results are in.
        if (k == n_items / 2) drain_results();
        send_request(($urandom_range(0, 29) == 0) ? REQ_RESTART : REQ_NEXT,
                     1'b0, mk_res(0, 0, 0, 0));
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d requests, %0d results, %0d register writes.",
             sent_total, got_total, writes_done);
    $display("Seen %0d last-prime flags and %0d exhausted results.",
             last_seen, exhausted_seen);
    if (fail_count == 0 && pending_primes.size() == 0) begin
      $display("segmented_prime_sieve_top test passed");
    end else begin
      $display("segmented_prime_sieve_top test failed");
    end
    $finish;
  end

endmodule
